[rtl/fmt_pkg.sv]
// ----------------------------------------------------------------------------
// fmt_pkg
// shared types and constants of the truncating single-precision multiplier
// ----------------------------------------------------------------------------
package fmt_pkg;

    localparam int unsigned EXP_W  = 8;
    localparam int unsigned FRAC_W = 23;
    localparam int unsigned SIG_W  = FRAC_W + 1;
    localparam int unsigned PROD_W = 2 * SIG_W;
    localparam logic [EXP_W-1:0] EXP_BIAS = 8'd127;

    typedef struct packed {
        logic              sign;
        logic [EXP_W-1:0]  expo;
        logic [FRAC_W-1:0] frac;
    } float_t;

endpackage

[rtl/float32_multiply_truncating.sv]
// an accepted operand pair passes the input register, then the result register, to product valid
// throughput: one operand pair per cycle, sustained with ready held high
// the result register stalls the input stage only when it is full and not taken
// reset: rst_n asynchronous, active low, clears the valid flags only
// ----------------------------------------------------------------------------
// float32_multiply_truncating
// single-precision multiplier with truncation and a two-register pipeline
// ----------------------------------------------------------------------------
module float32_multiply_truncating
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] product
);

    logic            s1_valid_reg;
    logic            s2_valid_reg;
    fmt_pkg::float_t a_reg;
    fmt_pkg::float_t b_reg;
    fmt_pkg::float_t p_next;
    fmt_pkg::float_t p_reg;
    logic            s2_ready;
    logic            s1_ready;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    fmt_core u_core
    (
        .a (a_reg),
        .b (b_reg),
        .p (p_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            a_reg <= operand_a;
            b_reg <= operand_b;
        end
        if (s2_ready && s1_valid_reg)
            p_reg <= p_next;
    end

    assign out_valid = s2_valid_reg;
    assign product   = p_reg;

endmodule

[rtl/fmt_core.sv]
// ----------------------------------------------------------------------------
// fmt_core
// combinational product: zero test, significand multiply, normalise, truncate
// ----------------------------------------------------------------------------
module fmt_core
(
    input  fmt_pkg::float_t a,
    input  fmt_pkg::float_t b,
    output fmt_pkg::float_t p
);

    logic                        sign;
    logic                        is_zero;
    logic [fmt_pkg::PROD_W-1:0]  prod;
    logic                        norm;
    logic [fmt_pkg::EXP_W-1:0]   expo;
    logic [fmt_pkg::FRAC_W-1:0]  frac;

    assign sign    = a.sign ^ b.sign;
    assign is_zero = (a.expo == '0 && a.frac == '0) || (b.expo == '0 && b.frac == '0);
    assign prod    = {{fmt_pkg::SIG_W{1'b0}}, 1'b1, a.frac}
                   * {{fmt_pkg::SIG_W{1'b0}}, 1'b1, b.frac};
    assign norm    = prod[fmt_pkg::PROD_W-1];
    assign frac    = norm ? prod[fmt_pkg::PROD_W-2 -: fmt_pkg::FRAC_W]
                          : prod[fmt_pkg::PROD_W-3 -: fmt_pkg::FRAC_W];
    assign expo    = a.expo + b.expo + {7'd0, norm} - fmt_pkg::EXP_BIAS;

    always_comb
    begin
        p.sign = sign;
        if (is_zero)
        begin
            p.expo = '0;
            p.frac = '0;
        end
        else
        begin
            p.expo = expo;
            p.frac = frac;
        end
    end

endmodule

[rtl/fmt_checker.sv]
// ----------------------------------------------------------------------------
// fmt_checker
// port-level checks of the multiplier handshake and pipeline
// ----------------------------------------------------------------------------
module fmt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [31:0] operand_a,
    input logic [31:0] operand_b,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] product
);

    // stalled product holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(product))
        else $error("stalled product changed");

    // ready whenever the output is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    // transfer with out_ready held shows up as out_valid after the input and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_ready ##1 out_ready |=> out_valid)
        else $error("transfer lost");

    // zero operand gives signed zero
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (operand_a[30:0] == 31'd0 || operand_b[30:0] == 31'd0)
        && out_ready ##1 out_ready
        |=> product[30:0] == 31'd0)
        else $error("zero operand not zero product");

endmodule

bind float32_multiply_truncating fmt_checker u_fmt_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .product   (product)
);
